@@ hdl/ptc_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ptc_pkg
// Types, widths and constants shared by the pressure/temperature
// compensation pipeline.
// ============================================================================
package ptc_pkg;

  // Port widths.
  localparam int RAW_W  = 24;
  localparam int CAL_W  = 16;
  localparam int IDX_W  = 3;
  localparam int TOUT_W = 19;
  localparam int POUT_W = 24;

  // Internal widths, sized from the value ranges of each intermediate.
  localparam int DT_W    = 25;  // raw temperature minus reference
  localparam int TC_W    = 42;  // products of dT with a calibration word
  localparam int DTSQ_W  = 48;  // dT squared
  localparam int T2M_W   = 52;  // dT squared times a small constant
  localparam int T2_W    = 17;  // T2 correction
  localparam int OB_W    = 38;  // first-order offset
  localparam int SB_W    = 36;  // first-order sensitivity
  localparam int SQP_W   = 38;  // signed product of two temperature deltas
  localparam int SQ_W    = 35;  // squared temperature delta
  localparam int OFF2_W  = 41;  // second-order offset
  localparam int SENS2_W = 40;  // second-order sensitivity
  localparam int OFF_W   = 43;  // final offset
  localparam int SENS_W  = 41;  // final sensitivity
  localparam int SPLIT   = 20;  // low part of the sensitivity multiply
  localparam int PLO_W   = RAW_W + SPLIT;
  localparam int PHI_W   = 46;
  localparam int PROD_W  = 66;
  localparam int DIFF_W  = 46;

  // Formula constants.
  localparam int T_REF         = 2000;
  localparam int T_COLD        = -1500;
  localparam int REF_T_SH      = 8;
  localparam int TEMP_SH       = 23;
  localparam int OFF_BASE_SH   = 17;
  localparam int SENS_BASE_SH  = 16;
  localparam int OFF_TC_SH     = 6;
  localparam int SENS_TC_SH    = 7;
  localparam int T2_COOL_MUL   = 3;
  localparam int T2_COOL_SH    = 33;
  localparam int T2_WARM_MUL   = 5;
  localparam int T2_WARM_SH    = 38;
  localparam int OFF2_MUL      = 61;
  localparam int SENS2_MUL     = 29;
  localparam int SECOND_SH     = 4;
  localparam int OFF2_COLD_MUL = 17;
  localparam int SENS2_COLD_MUL = 9;
  localparam int PROD_SH       = 21;
  localparam int P_SH          = 15;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_SENS_BASE   = 3'd0,
    REG_OFFSET_BASE = 3'd1,
    REG_SENS_TC     = 3'd2,
    REG_OFFSET_TC   = 3'd3,
    REG_REF_TEMP    = 3'd4,
    REG_TEMP_SENS   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [CAL_W-1:0] sens_base;
    logic [CAL_W-1:0] offset_base;
    logic [CAL_W-1:0] sens_temp_coeff;
    logic [CAL_W-1:0] offset_temp_coeff;
    logic [CAL_W-1:0] ref_temperature;
    logic [CAL_W-1:0] temp_sensitivity;
  } cal_t;

  // Bundle handed from the temperature stages to the pressure stages.
  typedef struct packed {
    logic                     valid;
    logic                     nz;
    logic [RAW_W-1:0]         d1;
    logic signed [TOUT_W-1:0] tout;
    logic                     cool;
    logic                     cold;
    logic [SQ_W-1:0]          sq1;
    logic [SQ_W-1:0]          sq2;
    logic signed [OB_W-1:0]   off_base;
    logic signed [SB_W-1:0]   sens_base;
  } temp_res_t;

  typedef struct packed {
    logic                     valid;
    logic signed [TOUT_W-1:0] temperature;
    logic signed [POUT_W-1:0] pressure;
    logic                     reading_valid;
  } result_t;

endpackage

@@ hdl/ptc_temp_pipe.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ptc_temp_pipe
// Stages one to four: dT, first-order temperature, T2, first-order offset
// and sensitivity, and the squared temperature deltas.
// ============================================================================
module ptc_temp_pipe (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      in_valid_i,
  input  logic [ptc_pkg::RAW_W-1:0] raw_temperature_i,
  input  logic [ptc_pkg::RAW_W-1:0] raw_pressure_i,
  input  ptc_pkg::cal_t             cal_i,
  output ptc_pkg::temp_res_t        res_o
);
  import ptc_pkg::*;

  localparam logic signed [TOUT_W-1:0] DD_COLD = TOUT_W'(T_COLD - T_REF);
  localparam logic signed [TOUT_W-1:0] TREF_S  = TOUT_W'(T_REF);

  // Stage 1
  logic                   v1_q;
  logic                   nz1_q, nz1_d;
  logic [RAW_W-1:0]       d1_1_q;
  logic signed [DT_W-1:0] dt1_q, dt1_d;

  // Stage 2
  logic                   v2_q;
  logic                   nz2_q;
  logic [RAW_W-1:0]       d1_2_q;
  logic signed [TC_W-1:0] tc2_q, tc2_d;
  logic signed [TC_W-1:0] c4dt2_q, c4dt2_d;
  logic signed [TC_W-1:0] c3dt2_q, c3dt2_d;
  logic signed [2*DT_W-1:0] dtsq_full;
  logic [DTSQ_W-1:0]      dtsq2_q, dtsq2_d;

  // Stage 3
  logic                     v3_q;
  logic                     nz3_q;
  logic [RAW_W-1:0]         d1_3_q;
  logic signed [TC_W-1:0]   tc_sh;
  logic signed [TOUT_W-1:0] dd3_q, dd3_d;
  logic signed [TOUT_W-1:0] dd2_3_q, dd2_3_d;
  logic signed [TOUT_W-1:0] temp3_q, temp3_d;
  logic                     cool3_q, cool3_d;
  logic                     cold3_q, cold3_d;
  logic [T2M_W-1:0]         t2_cool_m, t2_warm_m;
  logic [T2_W-1:0]          t2_3_q, t2_3_d;
  logic signed [OB_W-1:0]   ob3_q, ob3_d;
  logic signed [SB_W-1:0]   sb3_q, sb3_d;

  // Stage 4
  logic                     v4_q;
  logic                     nz4_q;
  logic [RAW_W-1:0]         d1_4_q;
  logic signed [TOUT_W-1:0] tout4_q, tout4_d;
  logic                     cool4_q, cold4_q;
  logic signed [SQP_W-1:0]  sq1_full, sq2_full;
  logic [SQ_W-1:0]          sq1_4_q, sq1_4_d;
  logic [SQ_W-1:0]          sq2_4_q, sq2_4_d;
  logic signed [OB_W-1:0]   ob4_q;
  logic signed [SB_W-1:0]   sb4_q;

  // Stage 1: dT and the zero-reading check.
  assign nz1_d = (raw_temperature_i != '0) && (raw_pressure_i != '0);
  assign dt1_d = $signed({1'b0, raw_temperature_i})
               - $signed({1'b0, cal_i.ref_temperature, {REF_T_SH{1'b0}}});

  // Stage 2: every product of dT.
  assign tc2_d     = TC_W'(dt1_q) * TC_W'($signed({1'b0, cal_i.temp_sensitivity}));
  assign c4dt2_d   = TC_W'(dt1_q) * TC_W'($signed({1'b0, cal_i.offset_temp_coeff}));
  assign c3dt2_d   = TC_W'(dt1_q) * TC_W'($signed({1'b0, cal_i.sens_temp_coeff}));
  assign dtsq_full = (2*DT_W)'(dt1_q) * (2*DT_W)'(dt1_q);
  assign dtsq2_d   = dtsq_full[DTSQ_W-1:0];

  // Stage 3: temperature, T2 and the first-order terms. The distance from
  // the reference temperature is the shifted product itself.
  assign tc_sh   = tc2_q >>> TEMP_SH;
  assign dd3_d   = tc_sh[TOUT_W-1:0];
  assign temp3_d = dd3_d + TREF_S;
  assign cool3_d = tc2_q[TC_W-1];
  assign cold3_d = dd3_d < DD_COLD;
  assign dd2_3_d = dd3_d - DD_COLD;

  assign t2_cool_m = T2M_W'(dtsq2_q) * T2M_W'(T2_COOL_MUL);
  assign t2_warm_m = T2M_W'(dtsq2_q) * T2M_W'(T2_WARM_MUL);
  assign t2_3_d    = cool3_d ? T2_W'(t2_cool_m >> T2_COOL_SH)
                             : T2_W'(t2_warm_m >> T2_WARM_SH);

  assign ob3_d = OB_W'($signed({1'b0, cal_i.offset_base, {OFF_BASE_SH{1'b0}}}))
               + OB_W'(c4dt2_q >>> OFF_TC_SH);
  assign sb3_d = SB_W'($signed({1'b0, cal_i.sens_base, {SENS_BASE_SH{1'b0}}}))
               + SB_W'(c3dt2_q >>> SENS_TC_SH);

  // Stage 4: squares for the second-order terms and the final temperature.
  assign sq1_full = SQP_W'(dd3_q) * SQP_W'(dd3_q);
  assign sq2_full = SQP_W'(dd2_3_q) * SQP_W'(dd2_3_q);
  assign sq1_4_d  = sq1_full[SQ_W-1:0];
  assign sq2_4_d  = sq2_full[SQ_W-1:0];
  assign tout4_d  = temp3_q - TOUT_W'(t2_3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      nz1_q   <= nz1_d;
      d1_1_q  <= raw_pressure_i;
      dt1_q   <= dt1_d;

      nz2_q   <= nz1_q;
      d1_2_q  <= d1_1_q;
      tc2_q   <= tc2_d;
      c4dt2_q <= c4dt2_d;
      c3dt2_q <= c3dt2_d;
      dtsq2_q <= dtsq2_d;

      nz3_q   <= nz2_q;
      d1_3_q  <= d1_2_q;
      dd3_q   <= dd3_d;
      dd2_3_q <= dd2_3_d;
      temp3_q <= temp3_d;
      cool3_q <= cool3_d;
      cold3_q <= cold3_d;
      t2_3_q  <= t2_3_d;
      ob3_q   <= ob3_d;
      sb3_q   <= sb3_d;

      nz4_q   <= nz3_q;
      d1_4_q  <= d1_3_q;
      tout4_q <= tout4_d;
      cool4_q <= cool3_q;
      cold4_q <= cold3_q;
      sq1_4_q <= sq1_4_d;
      sq2_4_q <= sq2_4_d;
      ob4_q   <= ob3_q;
      sb4_q   <= sb3_q;
    end
  end

  always_comb begin
    res_o.valid     = v4_q;
    res_o.nz        = nz4_q;
    res_o.d1        = d1_4_q;
    res_o.tout      = tout4_q;
    res_o.cool      = cool4_q;
    res_o.cold      = cold4_q;
    res_o.sq1       = sq1_4_q;
    res_o.sq2       = sq2_4_q;
    res_o.off_base  = ob4_q;
    res_o.sens_base = sb4_q;
  end

endmodule

@@ hdl/ptc_press_pipe.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ptc_press_pipe
// Stages five to nine: second-order offset and sensitivity, the split
// pressure multiply, scaling, saturation and the output register.
// ============================================================================
module ptc_press_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  ptc_pkg::temp_res_t res_i,
  output ptc_pkg::result_t   res_o
);
  import ptc_pkg::*;

  localparam logic signed [DIFF_W-1:0] P_MAX_S = DIFF_W'((1 <<< (POUT_W-1)) - 1);
  localparam logic signed [DIFF_W-1:0] P_MIN_S = -DIFF_W'(1 <<< (POUT_W-1));

  // Stage 5
  logic                     v5_q;
  logic                     nz5_q;
  logic [RAW_W-1:0]         d1_5_q;
  logic signed [TOUT_W-1:0] tout5_q;
  logic [OFF2_W-1:0]        off2_warm, off2_cold, off2;
  logic [SENS2_W-1:0]       sens2_warm, sens2_cold, sens2;
  logic signed [OFF_W-1:0]  off5_q, off5_d;
  logic signed [SENS_W-1:0] sens5_q, sens5_d;

  // Stage 6
  logic                     v6_q;
  logic                     nz6_q;
  logic signed [TOUT_W-1:0] tout6_q;
  logic signed [OFF_W-1:0]  off6_q;
  logic [PLO_W-1:0]         plo6_q, plo6_d;
  logic signed [PHI_W-1:0]  phi6_q, phi6_d;

  // Stage 7
  logic                     v7_q;
  logic                     nz7_q;
  logic signed [TOUT_W-1:0] tout7_q;
  logic signed [OFF_W-1:0]  off7_q;
  logic signed [PROD_W-1:0] prod7_q, prod7_d;

  // Stage 8
  logic                     v8_q;
  logic                     nz8_q;
  logic signed [TOUT_W-1:0] tout8_q;
  logic signed [DIFF_W-1:0] diff8_q, diff8_d;

  // Stage 9 (output)
  logic                     v9_q;
  logic signed [DIFF_W-1:0] p_full;
  logic signed [POUT_W-1:0] pres9_q, pres9_d;
  logic signed [TOUT_W-1:0] temp9_q, temp9_d;
  logic                     rv9_q;

  // Stage 5: second-order terms apply only below the reference temperature.
  assign off2_warm  = (OFF2_W'(res_i.sq1) * OFF2_W'(OFF2_MUL)) >> SECOND_SH;
  assign off2_cold  = OFF2_W'(res_i.sq2) * OFF2_W'(OFF2_COLD_MUL);
  assign sens2_warm = (SENS2_W'(res_i.sq1) * SENS2_W'(SENS2_MUL)) >> SECOND_SH;
  assign sens2_cold = SENS2_W'(res_i.sq2) * SENS2_W'(SENS2_COLD_MUL);

  always_comb begin
    off2  = '0;
    sens2 = '0;
    if (res_i.cool) begin
      off2  = off2_warm;
      sens2 = sens2_warm;
      if (res_i.cold) begin
        off2  = off2_warm + off2_cold;
        sens2 = sens2_warm + sens2_cold;
      end
    end
  end

  assign off5_d  = OFF_W'(res_i.off_base) - OFF_W'(off2);
  assign sens5_d = SENS_W'(res_i.sens_base) - SENS_W'(sens2);

  // Stage 6: the pressure times sensitivity product in two halves.
  assign plo6_d = PLO_W'(d1_5_q) * PLO_W'(sens5_q[SPLIT-1:0]);
  assign phi6_d = PHI_W'($signed({1'b0, d1_5_q}))
                * PHI_W'($signed(sens5_q[SENS_W-1:SPLIT]));

  // Stage 7: recombine the halves.
  assign prod7_d = (PROD_W'(phi6_q) <<< SPLIT) + PROD_W'(plo6_q);

  // Stage 8: scale and remove the offset.
  assign diff8_d = DIFF_W'(prod7_q >>> PROD_SH) - DIFF_W'(off7_q);

  // Stage 9: final scale and saturation; a zero reading forces zeros.
  assign p_full = diff8_q >>> P_SH;

  always_comb begin
    pres9_d = '0;
    temp9_d = '0;
    if (nz8_q) begin
      temp9_d = tout8_q;
      priority if (p_full > P_MAX_S) begin
        pres9_d = P_MAX_S[POUT_W-1:0];
      end else if (p_full < P_MIN_S) begin
        pres9_d = P_MIN_S[POUT_W-1:0];
      end else begin
        pres9_d = p_full[POUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (adv_i) begin
      v5_q <= res_i.valid;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      nz5_q   <= res_i.nz;
      d1_5_q  <= res_i.d1;
      tout5_q <= res_i.tout;
      off5_q  <= off5_d;
      sens5_q <= sens5_d;

      nz6_q   <= nz5_q;
      tout6_q <= tout5_q;
      off6_q  <= off5_q;
      plo6_q  <= plo6_d;
      phi6_q  <= phi6_d;

      nz7_q   <= nz6_q;
      tout7_q <= tout6_q;
      off7_q  <= off6_q;
      prod7_q <= prod7_d;

      nz8_q   <= nz7_q;
      tout8_q <= tout7_q;
      diff8_q <= diff8_d;

      pres9_q <= pres9_d;
      temp9_q <= temp9_d;
      rv9_q   <= nz8_q;
    end
  end

  always_comb begin
    res_o.valid         = v9_q;
    res_o.temperature   = temp9_q;
    res_o.pressure      = pres9_q;
    res_o.reading_valid = rv9_q;
  end

endmodule

@@ hdl/pressure_temperature_compensation_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pressure_temperature_compensation_top
// Second-order pressure/temperature compensation of raw 24-bit sensor
// readings with six calibration words held in registers.
// ============================================================================
// The block accepts one item (raw temperature and raw pressure) per clock
// cycle and returns its result through a nine-stage pipeline; sustained
// throughput is one item per cycle, limited only by stall on the output,
// which freezes the whole pipeline while a finished result waits. Depth
// is set by the chain of multiplies: dT products, squared temperature
// deltas, second-order terms, and the 24 by 41 bit pressure multiply,
// done as two partial products recombined in the following stage.
// Calibration words are to be written through the write port only while
// no item is in flight; the block does not enforce this. Writes to unused
// indexes are dropped. A zero raw reading yields zeros, reading_valid_o low.
module pressure_temperature_compensation_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ptc_pkg::IDX_W-1:0]  cfg_index_i,
  input  logic [ptc_pkg::CAL_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ptc_pkg::RAW_W-1:0]  raw_temperature_i,
  input  logic [ptc_pkg::RAW_W-1:0]  raw_pressure_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [ptc_pkg::TOUT_W-1:0] temperature_centi_o,
  output logic signed [ptc_pkg::POUT_W-1:0] pressure_centi_o,
  output logic                       reading_valid_o
);
  import ptc_pkg::*;

  cal_t      cal_q, cal_d;
  logic      adv;
  temp_res_t temp_res;
  result_t   result;

  always_comb begin
    cal_d = cal_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SENS_BASE:   cal_d.sens_base         = cfg_data_i;
        REG_OFFSET_BASE: cal_d.offset_base       = cfg_data_i;
        REG_SENS_TC:     cal_d.sens_temp_coeff   = cfg_data_i;
        REG_OFFSET_TC:   cal_d.offset_temp_coeff = cfg_data_i;
        REG_REF_TEMP:    cal_d.ref_temperature   = cfg_data_i;
        REG_TEMP_SENS:   cal_d.temp_sensitivity  = cfg_data_i;
        default:         cal_d = cal_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  // The pipeline moves whenever the output register is empty or drained.
  assign adv        = !result.valid || !out_stall_i;
  assign in_stall_o = !adv;

  ptc_temp_pipe u_temp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .adv_i             (adv),
    .in_valid_i        (in_valid_i),
    .raw_temperature_i (raw_temperature_i),
    .raw_pressure_i    (raw_pressure_i),
    .cal_i             (cal_q),
    .res_o             (temp_res)
  );

  ptc_press_pipe u_press (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .res_i  (temp_res),
    .res_o  (result)
  );

  assign out_valid_o         = result.valid;
  assign temperature_centi_o = result.temperature;
  assign pressure_centi_o    = result.pressure;
  assign reading_valid_o     = result.reading_valid;

  // A flagged reading carries zeros in both fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !reading_valid_o) |->
      (temperature_centi_o == '0 && pressure_centi_o == '0))
    else $error("invalid reading with nonzero result fields");

  // With no result waiting, the input side is never held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while the output register is empty");

  // A write to the temperature sensitivity word lands in its register on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_index_i == REG_TEMP_SENS) |=>
      (cal_q.temp_sensitivity == $past(cfg_data_i)))
    else $error("calibration write lost");

endmodule

@@ tb/pressure_temperature_compensation_top_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pressure_temperature_compensation_top_tb
// Checks the pressure/temperature compensation block against a behavioral
// model of the second-order formulas. Each accepted reading pair is
// predicted at the moment of acceptance and compared with the next result
// that leaves the block. Calibration words are reloaded between phases
// while the block is empty. Sender gaps, receiver stalls and one long
// receiver hold-off per selected phase exercise the handshakes.
// ============================================================================
module pressure_temperature_compensation_top_tb;
  import ptc_pkg::*;

  localparam int NUM_CAL = 6;
  localparam int IDX_LIMIT = 1 << IDX_W;
  localparam logic [RAW_W-1:0] RAW_MAX = '1;
  localparam int HOLD_CYCLES = 120;

  typedef struct packed {
    logic [RAW_W-1:0] raw_temperature;
    logic [RAW_W-1:0] raw_pressure;
  } sensor_reading_t;

  typedef struct packed {
    logic signed [TOUT_W-1:0] temperature;
    logic signed [POUT_W-1:0] pressure;
    logic                     reading_valid;
  } compensated_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i = 1'b0;
  logic [IDX_W-1:0]         cfg_index_i = '0;
  logic [CAL_W-1:0]         cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [RAW_W-1:0]         raw_temperature_i = '0;
  logic [RAW_W-1:0]         raw_pressure_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [TOUT_W-1:0] temperature_centi_o;
  logic signed [POUT_W-1:0] pressure_centi_o;
  logic                     reading_valid_o;

  // Calibration words as the block holds them, and the set to load next.
  logic [CAL_W-1:0] cal_words [NUM_CAL] = '{default: '0};
  logic [CAL_W-1:0] next_cal [NUM_CAL];

  sensor_reading_t pending_readings [$];
  compensated_t    expected_compensated [$];
  sensor_reading_t accepted_reading;
  compensated_t    oldest;

  int          mismatch_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int          mode_left = 0;
  stall_mode_e stall_mode = STALL_NONE;

  pressure_temperature_compensation_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .raw_temperature_i   (raw_temperature_i),
    .raw_pressure_i      (raw_pressure_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .temperature_centi_o (temperature_centi_o),
    .pressure_centi_o    (pressure_centi_o),
    .reading_valid_o     (reading_valid_o)
  );

  always #4 clk_i = ~clk_i;

  // Second-order compensation with the current calibration words. All
  // intermediates are 64-bit signed and every shift is arithmetic.
  function automatic compensated_t compensate_reading(sensor_reading_t rd);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp, t2, off2, sens2, off, sens, p, dd, tout;
    compensated_t res;
    res = '0;
    d2 = rd.raw_temperature;
    d1 = rd.raw_pressure;
    if (d1 == 0 || d2 == 0) begin
      return res;
    end
    c1 = cal_words[REG_SENS_BASE];
    c2 = cal_words[REG_OFFSET_BASE];
    c3 = cal_words[REG_SENS_TC];
    c4 = cal_words[REG_OFFSET_TC];
    c5 = cal_words[REG_REF_TEMP];
    c6 = cal_words[REG_TEMP_SENS];

    dt = d2 - c5 * 256;
    temp = 2000 + ((dt * c6) >>> 23);
    if (temp < 2000) begin
      t2 = (3 * dt * dt) >>> 33;
      dd = temp - 2000;
      off2 = 61 * dd * dd / 16;
      sens2 = 29 * dd * dd / 16;
      if (temp < -1500) begin
        dd = temp + 1500;
        off2 = off2 + 17 * dd * dd;
        sens2 = sens2 + 9 * dd * dd;
      end
    end else begin
      t2 = (5 * dt * dt) >>> 38;
      off2 = 0;
      sens2 = 0;
    end

    off = c2 * 131072 + ((c4 * dt) >>> 6) - off2;
    sens = c1 * 65536 + ((c3 * dt) >>> 7) - sens2;
    p = (((d1 * sens) >>> 21) - off) >>> 15;
    if (p > 8388607) begin
      p = 8388607;
    end
    if (p < -8388608) begin
      p = -8388608;
    end
    tout = temp - t2;
    res.temperature = tout[TOUT_W-1:0];
    res.pressure = p[POUT_W-1:0];
    res.reading_valid = 1'b1;
    return res;
  endfunction

  function automatic logic [RAW_W-1:0] clamp_raw(longint v);
    if (v < 1) begin
      return RAW_W'(1);
    end
    if (v > (1 << RAW_W) - 1) begin
      return RAW_MAX;
    end
    return v[RAW_W-1:0];
  endfunction

  function automatic void push_reading(logic [RAW_W-1:0] t, logic [RAW_W-1:0] p);
    sensor_reading_t rd;
    rd.raw_temperature = t;
    rd.raw_pressure = p;
    pending_readings.push_back(rd);
  endfunction

  function automatic logic [CAL_W-1:0] random_cal_word();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      default: return CAL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Field extremes, zero readings, and the points right at and just below
  // 20.00 and -15.00 degrees for the words now loaded.
  task automatic queue_directed_readings();
    longint ref_point, c6, cold_dt;
    ref_point = longint'(cal_words[REG_REF_TEMP]) * 256;
    c6 = cal_words[REG_TEMP_SENS];
    push_reading(RAW_MAX, RAW_MAX);
    push_reading(RAW_W'(1), RAW_W'(1));
    push_reading(RAW_W'(1), RAW_MAX);
    push_reading(RAW_MAX, RAW_W'(1));
    push_reading('0, 24'h123456);
    push_reading(24'h654321, '0);
    push_reading('0, '0);
    push_reading(24'hAAAAAA, 24'h555555);
    push_reading(24'h555555, 24'hAAAAAA);
    push_reading(clamp_raw(ref_point), 24'h800000);
    push_reading(clamp_raw(ref_point - 1), 24'h800000);
    if (c6 != 0) begin
      cold_dt = -((longint'(3500) << 23) / c6);
      push_reading(clamp_raw(ref_point + cold_dt), 24'h400000);
      push_reading(clamp_raw(ref_point + cold_dt - 1), 24'h400000);
    end
    push_reading(RAW_W'(1), 24'h000100);
  endtask

  // Temperatures are spread around the reference point at several scales so
  // that warm, cool and cold branches all get hit.
  task automatic queue_random_readings(int count);
    longint ref_point, spread, t_val;
    logic [RAW_W-1:0] t_raw, p_raw;
    ref_point = longint'(cal_words[REG_REF_TEMP]) * 256;
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: spread = 1 << 12;
        1: spread = 1 << 18;
        2: spread = 1 << 22;
        default: spread = 1 << 24;
      endcase
      t_val = ref_point + longint'($urandom_range(0, 2 * spread)) - spread;
      t_raw = clamp_raw(t_val);
      case ($urandom_range(0, 39))
        0: t_raw = '0;
        1, 2: t_raw = RAW_W'($urandom_range(0, RAW_MAX));
        default: ;
      endcase
      case ($urandom_range(0, 39))
        0: p_raw = '0;
        1, 2, 3, 4: p_raw = RAW_MAX;
        5, 6, 7, 8, 9: p_raw = RAW_W'($urandom_range(1, 255));
        default: p_raw = RAW_W'($urandom_range(0, RAW_MAX));
      endcase
      push_reading(t_raw, p_raw);
    end
  endtask

  // The unused indexes get written too; the block must drop those writes.
  task automatic load_calibration();
    for (int i = 0; i < IDX_LIMIT; i++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_index_i <= i[IDX_W-1:0];
      if (i < NUM_CAL) begin
        cfg_data_i <= next_cal[i];
        cal_words[i] = next_cal[i];
      end else begin
        cfg_data_i <= CAL_W'($urandom_range(0, 65535));
      end
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(bit with_directed, int count, bit with_hold);
    if (with_directed) begin
      queue_directed_readings();
    end
    queue_random_readings(count);
    if (with_hold) begin
      hold_requests <= hold_requests + 1;
    end
    while (pending_readings.size() != 0 || expected_compensated.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
  endtask

  // Sender: items go out in bursts separated by random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        accepted_reading = pending_readings.pop_front();
        expected_compensated.push_back(compensate_reading(accepted_reading));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_readings.size() != 0) begin
          in_valid_i <= 1'b1;
          raw_temperature_i <= pending_readings[0].raw_temperature;
          raw_pressure_i <= pending_readings[0].raw_pressure;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
          end
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: a randomly chosen stall pattern is held for a random span; a requested
  // hold-off keeps it stalled long enough to back the pipeline up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (stall_mode)
          STALL_NONE: out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_compensated.size() == 0) begin
        $error("result with no item outstanding: temperature_centi %0d, pressure_centi %0d",
               temperature_centi_o, pressure_centi_o);
        mismatch_count++;
      end else begin
        oldest = expected_compensated.pop_front();
        if (temperature_centi_o !== oldest.temperature) begin
          $error("temperature_centi: expected %0d, got %0d",
                 oldest.temperature, temperature_centi_o);
          mismatch_count++;
        end
        if (pressure_centi_o !== oldest.pressure) begin
          $error("pressure_centi: expected %0d, got %0d", oldest.pressure, pressure_centi_o);
          mismatch_count++;
        end
        if (reading_valid_o !== oldest.reading_valid) begin
          $error("reading_valid: expected %0d, got %0d", oldest.reading_valid, reading_valid_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Calibration still at its reset value of all zeros.
    run_phase(1'b0, 45, 1'b0);

    next_cal = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
    load_calibration();
    run_phase(1'b1, 55, 1'b1);

    next_cal = '{default: '1};
    load_calibration();
    run_phase(1'b0, 55, 1'b0);

    // Hot extreme: reference at zero, steepest temperature slope.
    next_cal[REG_REF_TEMP] = '0;
    load_calibration();
    run_phase(1'b0, 50, 1'b0);

    next_cal = '{default: '0};
    load_calibration();
    run_phase(1'b0, 40, 1'b0);

    for (int n = 0; n < 5; n++) begin
      foreach (next_cal[k]) begin
        next_cal[k] = random_cal_word();
      end
      load_calibration();
      run_phase(1'b0, 55, n == 2);
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ pressure_temperature_compensation_top.f @@
hdl/ptc_pkg.sv
hdl/ptc_temp_pipe.sv
hdl/ptc_press_pipe.sv
hdl/pressure_temperature_compensation_top.sv
tb/pressure_temperature_compensation_top_tb.sv
